// File: sv/lookahead_halfwave_peak_limiter_defines.svh
// assertion helpers for the limiter
`ifndef LOOKAHEAD_HALFWAVE_PEAK_LIMITER_DEFINES_SVH
`define LOOKAHEAD_HALFWAVE_PEAK_LIMITER_DEFINES_SVH

// checked while out of reset
`define LHPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge
`define LHPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/lhpl_pkg.sv
`default_nettype none
package lhpl_pkg;

  localparam int BLOCK_SIZE_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int THR_W = 23;
  localparam int ENV_W = 23;
  localparam int EXT_W = 34;

  localparam int EPS_Q    = 419;
  localparam int MAKEUP_Q = 4185915;
  localparam int ENV_MAX  = 8388607;
  localparam logic [THR_W-1:0] ONE_Q = 23'd4194304;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV1,
    ST_MKMUL,
    ST_MKCHK,
    ST_DIV2,
    ST_FIN,
    ST_SCAN
  } lhpl_state_e;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_FRD,
    SC_FWR,
    SC_BRD,
    SC_BWR
  } scan_state_e;

  typedef struct packed {
    logic start;
    logic first;
  } scan_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scan_rsp_t;

endpackage
`default_nettype wire

// File: sv/lhpl_in_if.sv
`default_nettype none
interface lhpl_in_if import lhpl_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

// File: sv/lhpl_out_if.sv
`default_nettype none
interface lhpl_out_if import lhpl_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] result_sample;

  modport source (output valid, output result_sample, input ready);
  modport sink (input valid, input result_sample, output ready);
endinterface
`default_nettype wire

// File: sv/lookahead_halfwave_peak_limiter.sv
// latency: a sample leaves two blocks (2*BLOCK_SIZE beats) after it enters
// per beat: plain runs IDLE, LOAD, FIN; gain reduction adds a division, and make-up a multiply,
// a saturation check and, if none, a division; both use the shared one-bit-per-cycle divider
// the last beat of a block adds a two-pass scan (forward, backward; a read and a write an entry)
// reset: async active low, control registers to defaults, first two blocks of output are zero
`include "lookahead_halfwave_peak_limiter_defines.svh"
`default_nettype none
module lookahead_halfwave_peak_limiter import lhpl_pkg::*; #(
  parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [THR_W-1:0]     cfg_wdata_i,
  lhpl_in_if.sink              in_i,
  lhpl_out_if.source           out_o
);
  localparam int SB = SAMPLE_BITS;
  localparam int IW = $clog2(BLOCK_SIZE);
  localparam int AW = $clog2(4 * BLOCK_SIZE);
  localparam int NW = SB + THR_W;
  localparam logic [IW-1:0] WP_LAST = IW'(BLOCK_SIZE - 1);
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  lhpl_state_e state_q, state_d;
  logic [THR_W-1:0] thr_q;
  logic             byp_q, mk_q;
  logic [IW-1:0]    wp_q, wp_d;
  logic [1:0]       blk_q, blk_d;
  logic [1:0]       play_blk;
  logic [1:0]       primed_q, primed_d;
  logic             out_valid_q, out_valid_d;
  logic signed [SB-1:0] out_data_q, out_data_d;
  logic signed [SB-1:0] f_q, f_d;
  logic             neg_q, neg_d;
  logic [NW-1:0]    prod_q, prod_d;

  logic signed [SB-1:0] smem [4*BLOCK_SIZE];
  logic signed [SB-1:0] samp_q;
  logic [AW-1:0]    waddr, raddr;
  logic             accept, smem_re, out_free, ovf, env_gt;
  logic [SB-1:0]    mag_s, mag_f;

  scan_req_t        scan_req;
  scan_rsp_t        scan_rsp;
  logic             scan_samp_re;
  logic [IW-1:0]    scan_samp_idx;
  logic [ENV_W-1:0] env_data;

  logic             div_start, div_done;
  logic [NW-1:0]    div_num;
  logic [THR_W-1:0] div_den;
  logic [SB-1:0]    quot;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign mag_s    = samp_q[SB-1] ? SB'(-samp_q) : SB'(samp_q);
  assign mag_f    = f_q[SB-1] ? SB'(-f_q) : SB'(f_q);
  assign ovf      = prod_q[NW-1:SB] >= thr_q;
  assign env_gt   = env_data > thr_q;

  // sample store: four banks, the played block is two banks behind
  assign play_blk = blk_q - 2'd2;
  assign waddr   = AW'(blk_q) * AW'(BLOCK_SIZE) + AW'(wp_q);
  assign raddr   = scan_rsp.busy ? AW'(blk_q) * AW'(BLOCK_SIZE) + AW'(scan_samp_idx)
                                 : AW'(play_blk) * AW'(BLOCK_SIZE) + AW'(wp_q);
  assign smem_re = accept || scan_samp_re;

  always_ff @(posedge clk_i) begin
    if (accept) smem[waddr] <= in_i.sample;
    if (smem_re) samp_q <= smem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ONE_Q;
      byp_q <= 1'b0;
      mk_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thr_q <= cfg_wdata_i;
        CFG_BYPASS:    byp_q <= cfg_wdata_i[0];
        CFG_MAKEUP:    mk_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_LOAD;
      ST_LOAD: begin
        if (!primed_q[1] || byp_q) state_d = ST_FIN;
        else if (env_gt) state_d = ST_DIV1;
        else if (mk_q) state_d = ST_MKMUL;
        else state_d = ST_FIN;
      end
      ST_DIV1:  if (div_done) state_d = mk_q ? ST_MKMUL : ST_FIN;
      ST_MKMUL: state_d = (f_q == '0) ? ST_FIN : ST_MKCHK;
      ST_MKCHK: state_d = ovf ? ST_FIN : ST_DIV2;
      ST_DIV2:  if (div_done) state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = (wp_q == WP_LAST) ? ST_SCAN : ST_IDLE;
      ST_SCAN:  if (scan_rsp.done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready     = (state_q == ST_IDLE);
    div_start      = 1'b0;
    div_num        = prod_q;
    div_den        = thr_q;
    scan_req.start = 1'b0;
    scan_req.first = (primed_q == 2'd0);
    wp_d           = wp_q;
    blk_d          = blk_q;
    primed_d       = primed_q;
    f_d            = f_q;
    neg_d          = neg_q;
    prod_d         = prod_q;
    out_data_d     = out_data_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    unique case (state_q)
      ST_LOAD: begin
        neg_d   = samp_q[SB-1];
        div_num = NW'(mag_s) * NW'(thr_q);
        div_den = env_data;
        if (!primed_q[1]) begin
          f_d = '0;
        end else if (!byp_q && env_gt) begin
          div_start = 1'b1;
        end else begin
          f_d = samp_q;
        end
      end
      ST_DIV1: if (div_done) f_d = neg_q ? -SB'(quot) : SB'(quot);
      ST_MKMUL: begin
        prod_d = NW'(mag_f) * NW'(MAKEUP_Q);
        neg_d  = f_q[SB-1];
      end
      ST_MKCHK: begin
        if (ovf) f_d = neg_q ? SMIN : SMAX;
        else div_start = 1'b1;
      end
      ST_DIV2: begin
        if (div_done) begin
          if (neg_q) f_d = quot[SB-1] ? SMIN : -SB'(quot);
          else f_d = quot[SB-1] ? SMAX : SB'(quot);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = f_q;
          if (wp_q == WP_LAST) begin
            wp_d           = '0;
            scan_req.start = 1'b1;
          end else begin
            wp_d = wp_q + 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          blk_d = blk_q + 1'b1;
          if (!primed_q[1]) primed_d = primed_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      blk_q       <= '0;
      primed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      blk_q       <= blk_d;
      primed_q    <= primed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q        <= f_d;
    neg_q      <= neg_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_sample = out_data_q;

  lhpl_div #(
    .DW (THR_W),
    .QW (SB),
    .NW (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  lhpl_scan #(
    .BLOCK_SIZE  (BLOCK_SIZE),
    .SAMPLE_BITS (SB)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (scan_req),
    .rsp_o       (scan_rsp),
    .samp_re_o   (scan_samp_re),
    .samp_idx_o  (scan_samp_idx),
    .samp_data_i (samp_q),
    .env_re_i    (accept),
    .env_idx_i   (wp_q),
    .env_data_o  (env_data)
  );

  `LHPL_ASSERT(a_scan_blocks_input, scan_rsp.busy |-> !in_i.ready, "beat taken during scan")
  `LHPL_ASSERT(a_accept_loads, accept |=> (state_q == ST_LOAD), "accept did not start load")
  `LHPL_ASSERT(a_silent_start, (out_valid_q && !primed_q[1]) |-> (out_data_q == '0), "not silent")
  `LHPL_ASSERT(a_scan_done_in_scan, scan_rsp.done |-> (state_q == ST_SCAN), "scan done early")
endmodule
`default_nettype wire

// File: sv/lhpl_div.sv
`default_nettype none
module lhpl_div import lhpl_pkg::*; #(
  parameter int DW = THR_W,
  parameter int QW = SAMPLE_BITS_DEF,
  parameter int NW = DW + QW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);
  localparam int CW = $clog2(QW + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] sh_q, sh_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial  = {rem_q, sh_q[QW-1]};
    diff   = trial - {1'b0, den_q};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i[NW-1:QW];
      sh_d   = num_i[QW-1:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_d  = {sh_q[QW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;
endmodule
`default_nettype wire

// File: sv/lhpl_scan.sv
`default_nettype none
module lhpl_scan import lhpl_pkg::*; #(
  parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scan_req_t                     req_i,
  output scan_rsp_t                     rsp_o,
  output logic                          samp_re_o,
  output logic [$clog2(BLOCK_SIZE)-1:0] samp_idx_o,
  input  logic signed [SAMPLE_BITS-1:0] samp_data_i,
  input  logic                          env_re_i,
  input  logic [$clog2(BLOCK_SIZE)-1:0] env_idx_i,
  output logic [ENV_W-1:0]              env_data_o
);
  localparam int SB  = SAMPLE_BITS;
  localparam int IW  = $clog2(BLOCK_SIZE);
  localparam int SAW = $clog2(2 * BLOCK_SIZE);
  localparam logic [IW-1:0] LO_LAST = IW'(BLOCK_SIZE - 1);
  localparam logic signed [SB-1:0] EPS_P = SB'(EPS_Q);
  localparam logic signed [SB-1:0] EPS_N = SB'(-EPS_Q);
  localparam logic signed [EXT_W-1:0] ENV_MAX_X = EXT_W'(ENV_MAX);

  scan_state_e st_q, st_d;
  logic           h_q, h_d;
  logic [IW-1:0]  lo_q, lo_d;
  logic           base_q, base_d;
  logic           first_q, first_d;
  logic           prun_q, prun_d, nrun_q, nrun_d;
  logic signed [SB-1:0] pacc_q, pacc_d, nacc_q, nacc_d;

  logic signed [SB-1:0] pmem [2*BLOCK_SIZE];
  logic signed [SB-1:0] nmem [2*BLOCK_SIZE];
  logic [ENV_W-1:0]     emem [BLOCK_SIZE];
  logic signed [SB-1:0] prd_q, nrd_q;
  logic [ENV_W-1:0]     erd_q;

  logic [SAW-1:0]       addr;
  logic                 mem_re, mem_we, env_we, last_pass;
  logic signed [SB-1:0] vp, vn, op, on;
  logic                 p_in, n_in;
  logic signed [EXT_W-1:0] mag_x;
  logic [ENV_W-1:0]     env_val;

  assign addr = SAW'(h_q ^ base_q) * SAW'(BLOCK_SIZE) + SAW'(lo_q);
  assign last_pass = (st_q == SC_FWR) ? (h_q && lo_q == LO_LAST) : (!h_q && lo_q == '0);

  // shared run fill unit
  always_comb begin
    if (st_q == SC_FWR && h_q) begin
      vp = samp_data_i;
      vn = samp_data_i;
    end else if (st_q == SC_FWR && first_q) begin
      vp = '0;
      vn = '0;
    end else begin
      vp = prd_q;
      vn = nrd_q;
    end
    p_in = vp > EPS_P;
    n_in = vn < EPS_N;
    op   = (p_in && prun_q && pacc_q > vp) ? pacc_q : vp;
    on   = (n_in && nrun_q && nacc_q < vn) ? nacc_q : vn;
    if (p_in) begin
      mag_x = EXT_W'(op);
    end else begin
      mag_x = -EXT_W'(on);
    end
    if (p_in || n_in) begin
      env_val = (mag_x > ENV_MAX_X) ? ENV_W'(ENV_MAX) : mag_x[ENV_W-1:0];
    end else begin
      env_val = ONE_Q;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SC_IDLE: if (req_i.start) st_d = SC_FRD;
      SC_FRD:  st_d = SC_FWR;
      SC_FWR:  st_d = last_pass ? SC_BRD : SC_FRD;
      SC_BRD:  st_d = SC_BWR;
      SC_BWR:  st_d = last_pass ? SC_IDLE : SC_BRD;
      default: st_d = SC_IDLE;
    endcase
  end

  always_comb begin
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    env_we     = 1'b0;
    samp_re_o  = 1'b0;
    samp_idx_o = lo_q;
    rsp_o.busy = (st_q != SC_IDLE);
    rsp_o.done = 1'b0;
    h_d        = h_q;
    lo_d       = lo_q;
    base_d     = base_q;
    first_d    = first_q;
    prun_d     = prun_q;
    nrun_d     = nrun_q;
    pacc_d     = pacc_q;
    nacc_d     = nacc_q;
    unique case (st_q) inside
      SC_IDLE: begin
        if (req_i.start) begin
          first_d = req_i.first;
          h_d     = 1'b0;
          lo_d    = '0;
          prun_d  = 1'b0;
          nrun_d  = 1'b0;
        end
      end
      SC_FRD: begin
        mem_re    = !h_q;
        samp_re_o = h_q;
      end
      SC_FWR, SC_BWR: begin
        mem_we = 1'b1;
        env_we = (st_q == SC_BWR) && !h_q;
        prun_d = p_in;
        nrun_d = n_in;
        pacc_d = op;
        nacc_d = on;
        if (st_q == SC_FWR) begin
          if (lo_q == LO_LAST) begin
            lo_d = last_pass ? LO_LAST : '0;
            h_d  = 1'b1;
            if (last_pass) begin
              prun_d = 1'b0;
              nrun_d = 1'b0;
            end
          end else begin
            lo_d = lo_q + 1'b1;
          end
        end else begin
          if (lo_q == '0) begin
            lo_d = LO_LAST;
            h_d  = 1'b0;
            if (last_pass) begin
              base_d     = !base_q;
              rsp_o.done = 1'b1;
            end
          end else begin
            lo_d = lo_q - 1'b1;
          end
        end
      end
      SC_BRD: mem_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SC_IDLE;
      h_q     <= 1'b0;
      lo_q    <= '0;
      base_q  <= 1'b0;
      first_q <= 1'b1;
      prun_q  <= 1'b0;
      nrun_q  <= 1'b0;
      pacc_q  <= '0;
      nacc_q  <= '0;
    end else begin
      st_q    <= st_d;
      h_q     <= h_d;
      lo_q    <= lo_d;
      base_q  <= base_d;
      first_q <= first_d;
      prun_q  <= prun_d;
      nrun_q  <= nrun_d;
      pacc_q  <= pacc_d;
      nacc_q  <= nacc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pmem[addr] <= op;
      nmem[addr] <= on;
    end
    if (mem_re) begin
      prd_q <= pmem[addr];
      nrd_q <= nmem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (env_we) emem[lo_q] <= env_val;
    if (env_re_i) erd_q <= emem[env_idx_i];
  end

  assign env_data_o = erd_q;
endmodule
`default_nettype wire
